// ===== src/highest_response_ratio_scheduler_defines.svh =====
// assertion helpers for the scheduler checker
`ifndef HIGHEST_RESPONSE_RATIO_SCHEDULER_DEFINES_SVH
`define HIGHEST_RESPONSE_RATIO_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HRRN_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HRRN_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define HRRN_ASSERT_ALWAYS(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hrrn_pkg.sv =====
package hrrn_pkg;

   localparam int ID_W     = 8;
   localparam int BURST_W  = 12;
   localparam int TICK_W   = 32;
   localparam int WAIT_W   = 20;
   localparam int RATIO_W  = WAIT_W + 1;
   localparam int ENTRY_W  = ID_W + BURST_W + TICK_W;
   localparam int DEF_MAX_TASKS = 16;

   // one table entry
   typedef struct packed {
      logic [TICK_W-1:0]  admit;
      logic [BURST_W-1:0] burst;
      logic [ID_W-1:0]    id;
   } entry_type;

   // divider request
   typedef struct packed {
      logic               start;
      logic [RATIO_W-1:0] num;
      logic [BURST_W-1:0] den;
   } div_req_type;

   // divider status
   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quot;
   } div_rsp_type;

   // zero burst behaves as one
   function automatic logic [BURST_W-1:0] eff_burst(input logic [BURST_W-1:0] b);
      return (b == '0) ? BURST_W'(1) : b;
   endfunction

endpackage

// ===== src/hrrn_div.sv =====
module hrrn_div (
   input  logic                clock,
   input  logic                reset,
   input  hrrn_pkg::div_req_type req,
   output hrrn_pkg::div_rsp_type rsp
);
   import hrrn_pkg::*;

   localparam int CNT_W = $clog2(RATIO_W + 1);

   logic [BURST_W-1:0] rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic [BURST_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BURST_W:0]   shifted;
   logic [BURST_W+1:0] diff;
   logic               ge;

   // one restoring step: shift in a numerator bit and try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[RATIO_W-1]};
      diff    = {1'b0, shifted} - {2'b0, den_ff};
      ge      = ~diff[BURST_W+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = CNT_W'(RATIO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[BURST_W-1:0] : shifted[BURST_W-1:0];
         quo_in = {quo_ff[RATIO_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

// ===== src/hrrn_table.sv =====
module hrrn_table #(
   parameter int MAX_TASKS = hrrn_pkg::DEF_MAX_TASKS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_TASKS)-1:0]  wr_addr,
   input  hrrn_pkg::entry_type           wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_TASKS)-1:0]  rd_addr,
   output hrrn_pkg::entry_type           rd_data
);
   import hrrn_pkg::*;

   entry_type mem [MAX_TASKS];
   entry_type rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/highest_response_ratio_scheduler.sv =====
// highest response ratio next scheduler, one tick per input transaction
// req channel: one transaction per scheduler tick; tuser flags an arriving
//   task, tdata carries its id and burst
// rsp channel: exactly one transaction per tick with finished, idle and
//   overflow flags and, on completion, the task's id, burst, admit, start
//   and end ticks
// with no dispatch needed a tick passes through the idle, tick and result
//   states; a dispatch reads each waiting entry and passes its ratio through
//   one shared 21-step restoring divider, then moves each later entry one
//   place down when the chosen task leaves the table (one read, one write port)
// req_tready is high only between ticks; the result sits in an output
//   register until rsp_tready, and the next tick is not taken before that
// reset empties the table, clears the running task and sets the tick to one;
//   no clearing pass is needed
module highest_response_ratio_scheduler #(
   parameter int MAX_TASKS = hrrn_pkg::DEF_MAX_TASKS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // arrival_id, arrival_burst, zero pad
   input  logic          req_tuser,   // arrival_valid
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // done_id, done_burst, admit_tick,
                                      // start_tick, end_tick, zero pad
   output logic [2:0]    rsp_tuser    // finished, idle, overflow
);
   import hrrn_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_SREAD = 10'b0000000010,
      S_SLOAD = 10'b0000000100,
      S_SDIV  = 10'b0000001000,
      S_PREAD = 10'b0000010000,
      S_PLOAD = 10'b0000100000,
      S_MREAD = 10'b0001000000,
      S_MWRITE= 10'b0010000000,
      S_TICK  = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [RATIO_W-1:0] best_ratio_ff, best_ratio_in;
   logic               run_ff, run_in;
   entry_type          rec_ff, rec_in;
   logic [BURST_W-1:0] remain_ff, remain_in;
   logic [TICK_W-1:0]  start_ff, start_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]         rsp_user_ff, rsp_user_in;

   logic               req_fire;
   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   entry_type          wr_data, rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [TICK_W-1:0]  age;
   logic [WAIT_W-1:0]  wait_sat;
   logic [BURST_W-1:0] remain_dec;
   logic [CNT_W-1:0]   next_pos;

   hrrn_table #(.MAX_TASKS(MAX_TASKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrrn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_fire = req_tvalid && req_tready;

   // wait of an entry is the saturated age since admission
   always_comb begin
      age      = tick_ff - rd_data.admit;
      wait_sat = (age >= TICK_W'({WAIT_W{1'b1}})) ? {WAIT_W{1'b1}} : age[WAIT_W-1:0];
      remain_dec = remain_ff - BURST_W'(1);
      next_pos   = CNT_W'(idx_ff) + CNT_W'(1);
   end

   // tick sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_ratio_in = best_ratio_ff;
      run_in        = run_ff;
      rec_in        = rec_ff;
      remain_in     = remain_ff;
      start_in      = start_ff;
      tick_in       = tick_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      wr_data       = '{admit: tick_ff, burst: req_tdata[19:8], id: req_tdata[7:0]};
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      div_req       = '{start: 1'b0,
                        num: RATIO_W'(wait_sat) + RATIO_W'(eff_burst(rd_data.burst)),
                        den: eff_burst(rd_data.burst)};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ovf_in = 1'b0;
               if (req_tuser) begin
                  if (cnt_ff == CNT_W'(MAX_TASKS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               idx_in  = '0;
               best_in = '0;
               if (!run_ff && cnt_in != '0) begin
                  state_in = S_SREAD;
               end else begin
                  state_in = S_TICK;
               end
            end
         end
         // scan: read one entry, divide, keep the best
         S_SREAD: begin
            rd_en    = 1'b1;
            state_in = S_SLOAD;
         end
         S_SLOAD: begin
            div_req.start = 1'b1;
            state_in      = S_SDIV;
         end
         S_SDIV: begin
            if (div_rsp.done) begin
               if (idx_ff == '0 || div_rsp.quot > best_ratio_ff) begin
                  best_in       = idx_ff;
                  best_ratio_in = div_rsp.quot;
               end
               if (next_pos == cnt_ff) begin
                  state_in = S_PREAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_SREAD;
               end
            end
         end
         // dispatch the chosen entry
         S_PREAD: begin
            rd_en    = 1'b1;
            rd_addr  = best_ff;
            state_in = S_PLOAD;
         end
         S_PLOAD: begin
            rec_in    = rd_data;
            remain_in = eff_burst(rd_data.burst);
            start_in  = tick_ff;
            run_in    = 1'b1;
            idx_in    = best_ff;
            state_in  = S_MREAD;
         end
         // close the gap: read each later entry and write it one place down
         S_MREAD: begin
            if (next_pos < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = next_pos[IDX_W-1:0];
               state_in = S_MWRITE;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_TICK;
            end
         end
         S_MWRITE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            idx_in   = idx_ff + IDX_W'(1);
            state_in = S_MREAD;
         end
         // count down and build the result
         S_TICK: begin
            rsp_data_in = '0;
            rsp_user_in = {ovf_ff, 1'b0, 1'b0};
            if (run_ff) begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  run_in         = 1'b0;
                  rsp_user_in[0] = 1'b1;
                  rsp_data_in    = {4'b0, tick_ff, start_ff, rec_ff.admit,
                                    rec_ff.burst, rec_ff.id};
               end
            end else begin
               rsp_user_in[1] = 1'b1;
            end
            tick_in      = tick_ff + TICK_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         run_ff       <= 1'b0;
         rec_ff       <= '0;
         remain_ff    <= '0;
         start_ff     <= '0;
         tick_ff      <= TICK_W'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         rec_ff       <= rec_in;
         remain_ff    <= remain_in;
         start_ff     <= start_in;
         tick_ff      <= tick_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_ratio_ff <= best_ratio_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== src/hrrn_checker.sv =====
`include "highest_response_ratio_scheduler_defines.svh"

module hrrn_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   // a tick is never taken while its result is still pending
   `HRRN_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "tick accepted twice")

   // a result cannot report both a completion and an idle tick
   `HRRN_ASSERT_NOW(a_fin_not_idle, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "finished and idle")

   // stalled result holds
   `HRRN_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed under stall")

   // reset leaves no result pending
   `HRRN_ASSERT_ALWAYS(a_reset_clear, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind highest_response_ratio_scheduler hrrn_checker u_hrrn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/tb_top.sv =====
module tb_top;
   import hrrn_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int WAIT_LIMIT  = 20'hFFFFF;
   localparam int WATCHDOG    = 20000;

   // one scheduler tick as seen on the output
   typedef struct {
      bit          finished;
      bit          idle;
      bit          overflow;
      bit [7:0]    id;
      bit [11:0]   burst;
      bit [31:0]   admit;
      bit [31:0]   start;
      bit [31:0]   fin;
   } tick_report_type;

   // directed stimulus row, with optional typed-in expectation
   typedef struct {
      bit         arrive;
      bit [7:0]   id;
      bit [11:0]  burst;
      bit         has_exp;
      bit         exp_fin;
      bit         exp_idle;
      bit         exp_ovf;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [23:0]   req_tdata;   // arrival_id, arrival_burst, zero pad
   logic          req_tuser;   // arrival_valid
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [119:0]  rsp_tdata;   // done_id, done_burst, admit_tick, start_tick, end_tick, pad
   logic [2:0]    rsp_tuser;   // finished, idle, overflow

   highest_response_ratio_scheduler dut (.*);

   // scheduler shadow state
   bit          q_valid [TABLE_DEPTH];
   bit [7:0]    q_id    [TABLE_DEPTH];
   bit [11:0]   q_burst [TABLE_DEPTH];
   bit [19:0]   q_wait  [TABLE_DEPTH];
   bit [31:0]   q_admit [TABLE_DEPTH];
   bit          run_busy;
   bit [7:0]    run_id;
   bit [11:0]   run_burst;
   bit [31:0]   run_admit;
   bit [11:0]   run_left;
   bit [31:0]   run_begin;
   bit [31:0]   now_tick;

   tick_report_type pending_reports[$];
   int  error_count;
   int  idle_cycles;
   bit  drain_gap;

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int table_fill();
      int n;
      n = 0;
      while (n < TABLE_DEPTH && q_valid[n]) n++;
      return n;
   endfunction

   // compute one tick of the scheduler
   function automatic tick_report_type schedule_tick(bit arrive, bit [7:0] id, bit [11:0] burst);
      tick_report_type r;
      int n, best;
      int unsigned ratio, best_ratio, b;
      r = '{default: 0};
      n = table_fill();
      if (arrive) begin
         if (n >= TABLE_DEPTH) r.overflow = 1;
         else begin
            q_valid[n] = 1; q_id[n] = id; q_burst[n] = burst;
            q_wait[n] = 0; q_admit[n] = now_tick;
            n++;
         end
      end
      // dispatch: highest ratio, earliest wins ties
      if (!run_busy && n > 0) begin
         best = 0; best_ratio = 0;
         for (int i = 0; i < n; i++) begin
            b = (q_burst[i] == 0) ? 1 : q_burst[i];
            ratio = (q_wait[i] + b) / b;
            if (i == 0 || ratio > best_ratio) begin
               best_ratio = ratio; best = i;
            end
         end
         run_id = q_id[best]; run_burst = q_burst[best]; run_admit = q_admit[best];
         run_left = (q_burst[best] == 0) ? 12'd1 : q_burst[best];
         run_begin = now_tick;
         run_busy = 1;
         for (int i = best; i + 1 < n; i++) begin
            q_id[i] = q_id[i+1]; q_burst[i] = q_burst[i+1];
            q_wait[i] = q_wait[i+1]; q_admit[i] = q_admit[i+1];
         end
         q_valid[n-1] = 0;
         n--;
      end
      if (run_busy) begin
         run_left = run_left - 1;
         for (int i = 0; i < n; i++)
            if (q_wait[i] < WAIT_LIMIT) q_wait[i]++;
         if (run_left == 0) begin
            r.finished = 1; r.id = run_id; r.burst = run_burst;
            r.admit = run_admit; r.start = run_begin; r.fin = now_tick;
            run_busy = 0;
         end
      end else r.idle = 1;
      now_tick++;
      return r;
   endfunction

   // drive one tick transaction and log its expectation
   task automatic send_tick(bit arrive, bit [7:0] id, bit [11:0] burst);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= arrive;
      req_tdata  <= {4'b0, burst, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_reports.insert(pending_reports.size(), schedule_tick(arrive, id, burst));
   endtask

   // stop offering ticks right at the accepting edge
   task automatic hold_off();
      req_tvalid <= 0;
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      tick_report_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result tuser=%b tdata=%h", $realtime,
                     rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            e = pending_reports.pop_front();
            if ({e.overflow, e.idle, e.finished} !== rsp_tuser) begin
               $display("%0t: flags expected %b actual %b", $realtime,
                        {e.overflow, e.idle, e.finished}, rsp_tuser);
               error_count++;
            end
            if ({e.fin, e.start, e.admit, e.burst, e.id} !== rsp_tdata[115:0]) begin
               $display("%0t: data expected %h actual %h", $realtime,
                        {e.fin, e.start, e.admit, e.burst, e.id}, rsp_tdata[115:0]);
               error_count++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         gap = drain_gap ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      directed_row_type rows[$];
      tick_report_type got;
      int burst_len, seq_len;
      bit [11:0] bmax;
      error_count = 0; idle_cycles = 0; drain_gap = 0;
      req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      reset = 1;
      for (int i = 0; i < TABLE_DEPTH; i++) q_valid[i] = 0;
      run_busy = 0; run_left = 0; run_begin = 0; now_tick = 1;
      repeat (12) @(posedge clock);
      reset <= 0;

      // empty tick after reset, single-tick tasks, zero burst, extremes
      rows.insert(rows.size(), directed_row_type'{0, 8'h00, 12'h000, 1, 0, 1, 0});
      rows.insert(rows.size(), directed_row_type'{1, 8'hFF, 12'd1,   1, 1, 0, 0});
      rows.insert(rows.size(), directed_row_type'{1, 8'h00, 12'd0,   1, 1, 0, 0});
      rows.insert(rows.size(), directed_row_type'{0, 8'hA5, 12'hFFF, 1, 0, 1, 0});
      rows.insert(rows.size(), directed_row_type'{1, 8'h5A, 12'd40,  0, 0, 0, 0});
      // fill the table past full while the long task runs
      for (int i = 0; i < 18; i++)
         rows.insert(rows.size(),
                     directed_row_type'{1, 8'(i), 12'(i % 5 == 0 ? 1 : i * 3), 0, 0, 0, 0});
      foreach (rows[k]) begin
         send_tick(rows[k].arrive, rows[k].id, rows[k].burst);
         if (rows[k].has_exp) begin
            got = pending_reports[$];
            if (got.finished != rows[k].exp_fin || got.idle != rows[k].exp_idle ||
                got.overflow != rows[k].exp_ovf) begin
               $display("%0t: directed row %0d expected %b%b%b actual %b%b%b", $realtime,
                        k, rows[k].exp_ovf, rows[k].exp_idle, rows[k].exp_fin,
                        got.overflow, got.idle, got.finished);
               error_count++;
            end
         end
      end
      // let the table drain with empty ticks
      while (run_busy || table_fill() > 0) send_tick(0, 8'($urandom), 12'($urandom));
      // full pause until every result is in
      hold_off();
      wait_drained();

      // random: runs of ticks, most with an arrival and mostly short tasks, sometimes a pause
      for (int n = 0; n < 950; ) begin
         seq_len = $urandom_range(1, 30);
         bmax = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(1, 12));
         for (int j = 0; j < seq_len; j++) begin
            burst_len = ($urandom_range(0, 40) == 0) ? 0 :
                        ($urandom_range(0, 60) == 0) ? 4095 : $urandom_range(1, bmax);
            send_tick($urandom_range(0, 2) != 0, 8'($urandom), 12'(burst_len));
            n++;
         end
         if ($urandom_range(0, 4) == 0) begin
            // full pause until every result is in, with receiver stalls on or off at random
            hold_off();
            drain_gap = $urandom_range(0, 1);
            wait_drained();
            drain_gap = 0;
         end
      end
      hold_off();
      wait_drained();
      repeat (500) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
